@@ src/pic_pkg.sv @@
package pic_pkg;

  localparam int MAX_SOURCES = 32;
  localparam int SRC_W       = 5;
  localparam int DATA_W      = 16;
  localparam int REG_W       = 32;
  localparam int LEVEL_W     = 13;
  localparam int PRIO_W      = 5;
  localparam int FIQ_BIT     = 8;
  localparam int TREE_NODES  = 2 * MAX_SOURCES - 1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LEVEL = 2'd2;

  localparam logic [7:0] OFF_PEND_LO = 8'h00;
  localparam logic [7:0] OFF_PEND_HI = 8'h02;
  localparam logic [7:0] OFF_MASK_LO = 8'h04;
  localparam logic [7:0] OFF_MASK_HI = 8'h06;
  localparam logic [7:0] OFF_IRQ_NUM = 8'h80;
  localparam logic [7:0] OFF_FIQ_NUM = 8'h82;
  localparam logic [7:0] OFF_ACK     = 8'h84;
  localparam logic [7:0] LEVEL_BASE  = 8'h20;
  localparam logic [7:0] LEVEL_END   = 8'h60;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        offset;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source;
    logic              level;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_out;
    logic              fiq_out;
    logic [SRC_W-1:0]  vector;
  } out_t;

  typedef struct packed {
    logic             none;
    logic [PRIO_W-1:0] prio;
    logic             fiq;
    logic [SRC_W-1:0] idx;
  } node_t;

  typedef struct packed {
    logic             found;
    logic             fiq;
    logic [SRC_W-1:0] idx;
  } arb_result_t;

endpackage

@@ src/priority_interrupt_controller_unit.sv @@
// Priority interrupt controller for up to NUM_SOURCES level-sensitive sources.
// Each input word is a 16-bit bus read, a bus write or a source level change,
// and each one produces exactly one result word carrying the read data, the
// IRQ and FIQ lines and the winning source number after that word. A word is
// registered on entry, its state update and the 32-way priority compare tree
// run while it sits in the input register, and the result lands in an output
// register, so the block takes one word per cycle while out_ready is high,
// and a result is valid once its word has passed the input register and then
// the output register. The compare tree between the two registers sets the
// clock period. The output register holds a result while out_ready is low,
// and one further word can still be taken into the input register.
module priority_interrupt_controller_unit
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = MAX_SOURCES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  in_t  in_r;
  logic in_valid_r;
  out_t out_r;
  logic out_valid_r;
  out_t result;
  logic advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  pic_core #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> in_valid_r)
    else $error("Accepted word was not captured.");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("Processed word produced no result.");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("Result word changed while it waited.");

endmodule

@@ src/pic_arbiter.sv @@
module pic_arbiter
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = MAX_SOURCES
) (
  input  logic [REG_W-1:0]   active,
  input  logic [LEVEL_W-1:0] level_words [NUM_SOURCES],
  output arb_result_t        result
);

  node_t leaves [MAX_SOURCES];
  node_t nodes  [TREE_NODES];

  for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_leaf
    if (k < NUM_SOURCES) begin : g_used
      assign leaves[k] = '{none: !active[k],
                           prio: level_words[k][PRIO_W-1:0],
                           fiq:  level_words[k][FIQ_BIT],
                           idx:  SRC_W'(k)};
    end else begin : g_unused
      assign leaves[k] = '{none: 1'b1, prio: '0, fiq: 1'b0, idx: '0};
    end
  end

  // Heap-ordered tree: left children cover lower source numbers, so a tie
  // keeps the left one.
  always_comb begin
    for (int k = 0; k < MAX_SOURCES; k++) begin
      nodes[MAX_SOURCES - 1 + k] = leaves[k];
    end
    for (int i = MAX_SOURCES - 2; i >= 0; i--) begin
      if (!nodes[2*i+1].none &&
          (nodes[2*i+2].none || nodes[2*i+1].prio <= nodes[2*i+2].prio)) begin
        nodes[i] = nodes[2*i+1];
      end else begin
        nodes[i] = nodes[2*i+2];
      end
    end
  end

  assign result.found = !nodes[0].none;
  assign result.fiq   = nodes[0].fiq;
  assign result.idx   = nodes[0].idx;

endmodule

@@ src/pic_core.sv @@
module pic_core
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = MAX_SOURCES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  item,
  output out_t result
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [REG_W-1:0]   pending_r, pending_nxt;
  logic [REG_W-1:0]   mask_r, mask_nxt;
  logic [LEVEL_W-1:0] level_r [NUM_SOURCES];
  logic [SRC_W-1:0]   winner_r, winner_nxt;
  logic               irq_r, irq_nxt;
  logic               fiq_r, fiq_nxt;

  logic [7:0]         lw_off;
  logic [SRC_W-1:0]   lw_idx;
  logic               lw_hit;
  logic               lw_we;
  logic               rearb;
  logic               src_ok;
  logic [DATA_W-1:0]  rd_data;
  arb_result_t        arb;

  assign lw_off = item.offset - LEVEL_BASE;
  assign lw_idx = lw_off[SRC_W:1];
  assign lw_hit = (item.offset >= LEVEL_BASE) && (item.offset < LEVEL_END) &&
                  ({1'b0, lw_idx} < (SRC_W+1)'(NUM_SOURCES));
  assign src_ok = {1'b0, item.source} < (SRC_W+1)'(NUM_SOURCES);
  assign lw_we  = (item.kind == KIND_WRITE) && lw_hit;

  always_comb begin
    pending_nxt = pending_r;
    mask_nxt    = mask_r;
    rearb       = 1'b0;
    unique case (item.kind)
      KIND_WRITE: begin
        unique case (item.offset)
          OFF_MASK_LO: begin
            mask_nxt = {mask_r[REG_W-1:DATA_W], item.write_data};
            rearb    = 1'b1;
          end
          OFF_MASK_HI: begin
            mask_nxt = {item.write_data, mask_r[DATA_W-1:0]};
            rearb    = 1'b1;
          end
          OFF_ACK: begin
            pending_nxt[winner_r] = 1'b0;
            rearb                 = 1'b1;
          end
          default: ;
        endcase
      end
      KIND_LEVEL: begin
        if (src_ok) begin
          pending_nxt[item.source] = item.level;
        end
        rearb = 1'b1;
      end
      default: ;
    endcase
  end

  pic_arbiter #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_arbiter (
    .active     (pending_nxt & ~mask_nxt),
    .level_words(level_r),
    .result     (arb)
  );

  always_comb begin
    winner_nxt = winner_r;
    irq_nxt    = irq_r;
    fiq_nxt    = fiq_r;
    if (rearb) begin
      winner_nxt = arb.found ? arb.idx : '0;
      irq_nxt    = arb.found && !arb.fiq;
      fiq_nxt    = arb.found && arb.fiq;
    end
  end

  always_comb begin
    rd_data = '0;
    if (item.kind == KIND_READ) begin
      unique case (item.offset)
        OFF_PEND_LO: rd_data = pending_r[DATA_W-1:0];
        OFF_PEND_HI: rd_data = pending_r[REG_W-1:DATA_W];
        OFF_MASK_LO: rd_data = mask_r[DATA_W-1:0];
        OFF_MASK_HI: rd_data = mask_r[REG_W-1:DATA_W];
        OFF_IRQ_NUM: rd_data = DATA_W'(winner_r);
        OFF_FIQ_NUM: rd_data = DATA_W'(winner_r);
        default: begin
          if (lw_hit) begin
            rd_data = DATA_W'(level_r[lw_idx[IDX_W-1:0]]);
          end
        end
      endcase
    end
  end

  assign result.read_data = rd_data;
  assign result.irq_out   = irq_nxt;
  assign result.fiq_out   = fiq_nxt;
  assign result.vector    = winner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      mask_r    <= '1;
      winner_r  <= '0;
      irq_r     <= 1'b0;
      fiq_r     <= 1'b0;
      for (int k = 0; k < NUM_SOURCES; k++) begin
        level_r[k] <= '0;
      end
    end else if (fire) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      winner_r  <= winner_nxt;
      irq_r     <= irq_nxt;
      fiq_r     <= fiq_nxt;
      for (int k = 0; k < NUM_SOURCES; k++) begin
        if (lw_we && (lw_idx == SRC_W'(k))) begin
          level_r[k] <= item.write_data[LEVEL_W-1:0];
        end
      end
    end
  end

  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(irq_r && fiq_r))
    else $error("IRQ and FIQ are both asserted.");

  a_vector_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    (winner_r != '0) |-> (irq_r || fiq_r))
    else $error("Nonzero vector without an active interrupt line.");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.kind == KIND_WRITE && item.offset == OFF_ACK)
      |=> !pending_r[$past(winner_r)])
    else $error("Acknowledge left the pending bit of the vector set.");

  a_mask_write: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.kind == KIND_WRITE && item.offset == OFF_MASK_LO)
      |=> (mask_r[DATA_W-1:0] == $past(item.write_data)))
    else $error("Low mask half does not hold the written word.");

endmodule
